// ----- sv/ofea_pkg.sv -----
// shared types, register indexes and constants of the optical flow error accumulator
package ofea_pkg;

  // one pixel request as it arrives
  typedef struct packed {
    logic signed [15:0] flow_u;
    logic signed [15:0] flow_v;
    logic signed [15:0] truth_u;
    logic signed [15:0] truth_v;
    logic               pixel_valid;
    logic               clear_stats;
  } ofea_in_t;

  // one result with the statistics after this pixel
  typedef struct packed {
    logic [15:0] angular_error;
    logic [16:0] endpoint_error;
    logic [31:0] valid_pixels;
    logic [47:0] angular_error_sum;
    logic [49:0] endpoint_error_sum;
    logic [31:0] angular_over_0;
    logic [31:0] angular_over_1;
    logic [31:0] angular_over_2;
    logic [31:0] endpoint_over_0;
    logic [31:0] endpoint_over_1;
    logic [31:0] endpoint_over_2;
  } ofea_out_t;

  // class of a pixel as the front part sees it
  typedef enum logic {
    KIND_MASKED,
    KIND_EVAL
  } ofea_kind_e;

  // queued job handed from front to back
  typedef struct packed {
    ofea_kind_e         kind;
    logic               clear;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] gu;
    logic signed [15:0] gv;
  } ofea_job_t;

  // front to back job channel
  typedef struct packed {
    logic      valid;
    ofea_job_t job;
  } ofea_fe_t;

  // configuration register indexes
  localparam logic [7:0] CFG_AE_THR_0 = 8'd0;
  localparam logic [7:0] CFG_AE_THR_1 = 8'd1;
  localparam logic [7:0] CFG_AE_THR_2 = 8'd2;
  localparam logic [7:0] CFG_EE_THR_0 = 8'd3;
  localparam logic [7:0] CFG_EE_THR_1 = 8'd4;
  localparam logic [7:0] CFG_EE_THR_2 = 8'd5;

  // threshold registers and reset values
  localparam int          CFG_THR     = 3;
  localparam logic [15:0] AE_THR_RST0 = 16'd640;
  localparam logic [15:0] AE_THR_RST1 = 16'd1280;
  localparam logic [15:0] AE_THR_RST2 = 16'd2560;
  localparam logic [16:0] EE_THR_RST0 = 17'd128;
  localparam logic [16:0] EE_THR_RST1 = 17'd256;
  localparam logic [16:0] EE_THR_RST2 = 17'd512;

  // limits
  localparam logic [15:0] AE_MAX  = 16'd46080;
  localparam logic [16:0] EE_MAX  = 17'h1FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] AS_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [49:0] ES_MAX  = 50'h3_FFFF_FFFF_FFFF;

  // angle rotation
  localparam int                 CORDIC_STEPS = 22;
  localparam logic signed [31:0] ANGLE_90     = 32'sd5898240;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234378;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ofea_isqrt.sv -----
// iterative integer square root, two operand bits per cycle
module ofea_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] arg_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q, res_q, bit_q;
  logic [63:0] trial;

  assign trial  = res_q + bit_q;
  assign busy_o = (bit_q != 64'd0);
  assign root_o = res_q[31:0];

  // bit position control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 64'd0;
    end else if (start_i) begin
      bit_q <= 64'd1 << 62;
    end else if (busy_o) begin
      bit_q <= bit_q >> 2;
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= arg_i;
      res_q <= 64'd0;
    end else if (busy_o) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

endmodule

// ----- sv/ofea_front.sv -----
// front part: accepts pixel requests, classifies them and queues them for the back part
module ofea_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  ofea_pkg::ofea_in_t  in_item_i,
  output ofea_pkg::ofea_fe_t  fe_o,
  input  logic                take_i
);

  ofea_pkg::ofea_job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  ofea_pkg::ofea_job_t job_w;

  // classify the pixel
  always_comb begin
    job_w.kind  = in_item_i.pixel_valid ? ofea_pkg::KIND_EVAL : ofea_pkg::KIND_MASKED;
    job_w.clear = in_item_i.clear_stats;
    job_w.u     = in_item_i.flow_u;
    job_w.v     = in_item_i.flow_v;
    job_w.gu    = in_item_i.truth_u;
    job_w.gv    = in_item_i.truth_v;
  end

  assign full_o    = (cnt_q == 2'd2);
  assign do_push   = push_i && !full_o;
  assign do_pop    = take_i && fe_o.valid;
  assign fe_o.valid = (cnt_q != 2'd0);
  assign fe_o.job   = mem_q[rd_ptr_q];

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_w;
  end

endmodule

// ----- sv/ofea_back.sv -----
// back part: error arithmetic, statistics and the result register
module ofea_back #(
  parameter int NUM_THRESHOLDS = 3,
  parameter int FLOW_FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ofea_pkg::ofea_fe_t  fe_i,
  output logic                take_o,
  input  logic [2:0][15:0]    ae_thr_i,
  input  logic [2:0][16:0]    ee_thr_i,
  output logic                empty_o,
  input  logic                pop_i,
  output ofea_pkg::ofea_out_t out_item_o
);

  localparam int EE_SHIFT = 24 - 2 * FLOW_FRAC_BITS;
  localparam int SLOTS    = 4;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SQ_ANG, S_WAIT_ANG, S_SQ_EE, S_WAIT_EE,
    S_PREP, S_NORM, S_ROT, S_FIN, S_STAT
  } state_e;

  state_e              state_q;
  ofea_pkg::ofea_job_t job_q;
  logic signed [31:0]  p_ugv_q, p_vgu_q, p_ugu_q, p_vgv_q;
  logic signed [16:0]  du_q, dv_q;
  logic [33:0]         sq_q;
  logic [63:0]         c3sq_q, csq_q;
  logic signed [39:0]  x_q, cx_q, cy_q;
  logic signed [31:0]  z_q;
  logic [31:0]         yroot_q;
  logic [4:0]          step_q;
  logic [15:0]         ae_q;
  logic [16:0]         ee_q;
  logic                out_valid_q;
  ofea_pkg::ofea_out_t out_q;

  logic [31:0] pix_q;
  logic [47:0] asum_q;
  logic [49:0] esum_q;
  logic [31:0] aover_q [SLOTS];
  logic [31:0] eover_q [SLOTS];

  // square root unit shared by both errors
  logic        sqrt_start, sqrt_busy;
  logic [63:0] sqrt_arg;
  logic [31:0] sqrt_root;

  assign sqrt_start = (state_q == S_SQ_ANG) || (state_q == S_SQ_EE);
  assign sqrt_arg   = (state_q == S_SQ_ANG) ? csq_q : (64'(sq_q) << EE_SHIFT);

  ofea_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .arg_i   (sqrt_arg),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // products and sums of the first steps
  logic signed [32:0] c3_w;
  logic signed [65:0] c3sq_w;
  logic signed [33:0] du_sq_w, dv_sq_w;
  logic signed [39:0] x_w;
  assign c3_w    = 33'(p_ugv_q) - 33'(p_vgu_q);
  assign c3sq_w  = c3_w * c3_w;
  assign du_sq_w = du_q * du_q;
  assign dv_sq_w = dv_q * dv_q;
  assign x_w     = (40'sd1 <<< (2 * FLOW_FRAC_BITS)) + 40'(p_ugu_q) + 40'(p_vgv_q);

  // endpoint rounding
  logic [28:0] ee_round;
  assign ee_round = 29'((33'(sqrt_root) + 33'd8) >> 4);

  // rotation step
  logic signed [39:0] xs_w, ys_w;
  logic signed [31:0] at_w;
  assign xs_w = cx_q >>> step_q;
  assign ys_w = cy_q >>> step_q;
  assign at_w = 32'(ofea_pkg::atan_q16(step_q));

  // angle rounding
  logic signed [31:0] z_round;
  assign z_round = (z_q + 32'sd128) >>> 8;

  // statistics after this pixel
  logic [31:0] pix_d;
  logic [47:0] asum_d;
  logic [49:0] esum_d;
  logic [31:0] aover_d [SLOTS];
  logic [31:0] eover_d [SLOTS];
  logic [15:0] ae_slot [SLOTS];
  logic [16:0] ee_slot [SLOTS];
  logic [48:0] asum_w;
  logic [50:0] esum_w;
  logic        do_eval;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      ae_slot[k] = (k < ofea_pkg::CFG_THR) ? ae_thr_i[2'(k)] : 16'd0;
      ee_slot[k] = (k < ofea_pkg::CFG_THR) ? ee_thr_i[2'(k)] : 17'd0;
    end
  end

  always_comb begin
    do_eval = (job_q.kind == ofea_pkg::KIND_EVAL);
    pix_d   = job_q.clear ? 32'd0 : pix_q;
    asum_d  = job_q.clear ? 48'd0 : asum_q;
    esum_d  = job_q.clear ? 50'd0 : esum_q;
    for (int k = 0; k < SLOTS; k++) begin
      aover_d[k] = job_q.clear ? 32'd0 : aover_q[k];
      eover_d[k] = job_q.clear ? 32'd0 : eover_q[k];
    end
    asum_w = {1'b0, asum_d} + 49'(ae_q);
    esum_w = {1'b0, esum_d} + 51'(ee_q);
    if (do_eval) begin
      if (pix_d != ofea_pkg::CNT_MAX) pix_d = pix_d + 32'd1;
      asum_d = asum_w[48] ? ofea_pkg::AS_MAX : asum_w[47:0];
      esum_d = esum_w[50] ? ofea_pkg::ES_MAX : esum_w[49:0];
      for (int k = 0; k < SLOTS; k++) begin
        if (k < NUM_THRESHOLDS) begin
          if (ae_q >= ae_slot[k] && aover_d[k] != ofea_pkg::CNT_MAX)
            aover_d[k] = aover_d[k] + 32'd1;
          if (ee_q >= ee_slot[k] && eover_d[k] != ofea_pkg::CNT_MAX)
            eover_d[k] = eover_d[k] + 32'd1;
        end
      end
    end
  end

  assign take_o     = (state_q == S_IDLE) && fe_i.valid;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // sequencer with its datapath and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pix_q       <= 32'd0;
      asum_q      <= 48'd0;
      esum_q      <= 50'd0;
      for (int k = 0; k < SLOTS; k++) begin
        aover_q[k] <= 32'd0;
        eover_q[k] <= 32'd0;
      end
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (fe_i.valid) begin
            job_q <= fe_i.job;
            ae_q  <= 16'd0;
            ee_q  <= 17'd0;
            state_q <= (fe_i.job.kind == ofea_pkg::KIND_EVAL) ? S_MUL1 : S_STAT;
          end
        end
        S_MUL1: begin
          p_ugv_q <= job_q.u * job_q.gv;
          p_vgu_q <= job_q.v * job_q.gu;
          p_ugu_q <= job_q.u * job_q.gu;
          p_vgv_q <= job_q.v * job_q.gv;
          du_q    <= 17'(job_q.u) - 17'(job_q.gu);
          dv_q    <= 17'(job_q.v) - 17'(job_q.gv);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          c3sq_q  <= c3sq_w[63:0];
          sq_q    <= $unsigned(du_sq_w) + $unsigned(dv_sq_w);
          x_q     <= x_w;
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          csq_q   <= (64'(sq_q) << (2 * FLOW_FRAC_BITS)) + c3sq_q;
          state_q <= S_SQ_ANG;
        end
        S_SQ_ANG: state_q <= S_WAIT_ANG;
        S_WAIT_ANG: begin
          if (!sqrt_busy) begin
            yroot_q <= sqrt_root;
            state_q <= S_SQ_EE;
          end
        end
        S_SQ_EE: state_q <= S_WAIT_EE;
        S_WAIT_EE: begin
          if (!sqrt_busy) begin
            ee_q    <= (ee_round > 29'(ofea_pkg::EE_MAX)) ? ofea_pkg::EE_MAX
                                                          : ee_round[16:0];
            state_q <= S_PREP;
          end
        end
        // turn by 90 degrees when the dot product is negative
        S_PREP: begin
          if (x_q < 40'sd0) begin
            cx_q <= 40'(yroot_q);
            cy_q <= -x_q;
            z_q  <= ofea_pkg::ANGLE_90;
          end else begin
            cx_q <= x_q;
            cy_q <= 40'(yroot_q);
            z_q  <= 32'sd0;
          end
          if (x_q == 40'sd0 && yroot_q == 32'd0) state_q <= S_STAT;
          else                                   state_q <= S_NORM;
        end
        // scale up until the larger part reaches 2^32
        S_NORM: begin
          step_q <= 5'd0;
          if ((cx_q[39:32] | cy_q[39:32]) == 8'd0) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (cy_q >= 40'sd0) begin
            cx_q <= cx_q + ys_w;
            cy_q <= cy_q - xs_w;
            z_q  <= z_q + at_w;
          end else begin
            cx_q <= cx_q - ys_w;
            cy_q <= cy_q + xs_w;
            z_q  <= z_q - at_w;
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'(ofea_pkg::CORDIC_STEPS - 1)) state_q <= S_FIN;
        end
        S_FIN: begin
          if (z_q < 32'sd0)                             ae_q <= 16'd0;
          else if (z_round > 32'(ofea_pkg::AE_MAX))     ae_q <= ofea_pkg::AE_MAX;
          else                                          ae_q <= z_round[15:0];
          state_q <= S_STAT;
        end
        // commit statistics once the result register is free
        S_STAT: begin
          if (!out_valid_q) begin
            pix_q  <= pix_d;
            asum_q <= asum_d;
            esum_q <= esum_d;
            for (int k = 0; k < SLOTS; k++) begin
              aover_q[k] <= aover_d[k];
              eover_q[k] <= eover_d[k];
            end
            out_q.angular_error      <= ae_q;
            out_q.endpoint_error     <= ee_q;
            out_q.valid_pixels       <= pix_d;
            out_q.angular_error_sum  <= asum_d;
            out_q.endpoint_error_sum <= esum_d;
            out_q.angular_over_0     <= aover_d[0];
            out_q.angular_over_1     <= aover_d[1];
            out_q.angular_over_2     <= aover_d[2];
            out_q.endpoint_over_0    <= eover_d[0];
            out_q.endpoint_over_1    <= eover_d[1];
            out_q.endpoint_over_2    <= eover_d[2];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/optical_flow_error_accumulator.sv -----
// top level: threshold registers, front queue, back datapath and checks
// In the back part a pixel passes the state that takes it from the queue,
// three product steps, two passes through the one shared square root unit
// (cross product length, then endpoint distance), one setup step, the
// normalization (longer for short vectors), 22 angle rotation steps, one
// rounding step and the commit of statistics. A masked pixel goes from the
// queue straight to the commit. A two-entry input queue takes new pixels while
// one is in work. A result register holds the finished result until it is
// popped, and the commit waits while it is full. The user must write thresholds
// only while the block is idle; the block itself does not enforce it.
module optical_flow_error_accumulator #(
  parameter int NUM_THRESHOLDS = 3,
  parameter int FLOW_FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ofea_pkg::ofea_in_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ofea_pkg::ofea_out_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i
);

  logic [2:0][15:0]   ae_thr_q;
  logic [2:0][16:0]   ee_thr_q;
  ofea_pkg::ofea_fe_t fe_ctl;
  logic               take;

  assign cfg_ready_o = 1'b1;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ae_thr_q[0] <= ofea_pkg::AE_THR_RST0;
      ae_thr_q[1] <= ofea_pkg::AE_THR_RST1;
      ae_thr_q[2] <= ofea_pkg::AE_THR_RST2;
      ee_thr_q[0] <= ofea_pkg::EE_THR_RST0;
      ee_thr_q[1] <= ofea_pkg::EE_THR_RST1;
      ee_thr_q[2] <= ofea_pkg::EE_THR_RST2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ofea_pkg::CFG_AE_THR_0: ae_thr_q[0] <= cfg_data_i[15:0];
        ofea_pkg::CFG_AE_THR_1: ae_thr_q[1] <= cfg_data_i[15:0];
        ofea_pkg::CFG_AE_THR_2: ae_thr_q[2] <= cfg_data_i[15:0];
        ofea_pkg::CFG_EE_THR_0: ee_thr_q[0] <= cfg_data_i;
        ofea_pkg::CFG_EE_THR_1: ee_thr_q[1] <= cfg_data_i;
        ofea_pkg::CFG_EE_THR_2: ee_thr_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ofea_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_item_i),
    .fe_o      (fe_ctl),
    .take_i    (take)
  );

  ofea_back #(
    .NUM_THRESHOLDS (NUM_THRESHOLDS),
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fe_i       (fe_ctl),
    .take_o     (take),
    .ae_thr_i   (ae_thr_q),
    .ee_thr_i   (ee_thr_q),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

  // a popped result is never replaced in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop && !empty |=> empty)
    else $error("result register refilled while being popped");

  // an accepted request leaves the queue non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) push && !full |=> fe_ctl.valid)
    else $error("accepted request lost from the input queue");

  // angular error stays within its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !empty |-> out_item_o.angular_error <= ofea_pkg::AE_MAX)
    else $error("angular error out of range");

endmodule

// ----- sim/optical_flow_error_accumulator_test.sv -----
// testbench of the optical flow error accumulator: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module optical_flow_error_accumulator_test;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  DRAIN_CYCLES   = 300;
  localparam int  RANDOM_PIXELS  = 470;

  // indexes past the register list, ignored by the block
  localparam logic [7:0] CFG_SPARE_LOW  = 8'd6;
  localparam logic [7:0] CFG_SPARE_HIGH = 8'hFF;

  // arctangent of 2^-i in degrees, 16 fraction bits
  localparam longint ROT_ANGLE [22] = '{
    2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  ofea_pkg::ofea_in_t  in_item_i;
  logic                empty;
  logic                pop;
  ofea_pkg::ofea_out_t out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [7:0]          cfg_index_i;
  logic [16:0]         cfg_data_i;

  // predictor copy of the thresholds and the statistics
  longint unsigned ang_thr [3];
  longint unsigned dist_thr [3];
  longint unsigned pixel_cnt;
  longint unsigned ang_sum;
  longint unsigned dist_sum;
  longint unsigned ang_over [3];
  longint unsigned dist_over [3];

  ofea_pkg::ofea_out_t pending_results [$];
  int                  errors;
  int                  send_idle_pct;
  int                  pop_stall_pct;
  int                  quiet_cycles;

  optical_flow_error_accumulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // rounded euclidean distance in Q.8
  function automatic longint unsigned dist_error(longint u, longint v, longint gu, longint gv);
    longint          du;
    longint          dv;
    longint unsigned sq;
    longint unsigned e;
    du = u - gu;
    dv = v - gv;
    sq = longint'(du * du) + longint'(dv * dv);
    e  = (int_sqrt(sq << 8) + 8) >> 4;
    return (e > 131071) ? 131071 : e;
  endfunction

  // angle between (u,v,1) and (gu,gv,1) in Q8.8 degrees
  function automatic longint unsigned angle_error(longint u, longint v, longint gu, longint gv);
    longint          c1;
    longint          c2;
    longint          c3;
    longint unsigned csq;
    longint          x;
    longint          y;
    longint          z;
    longint          t;
    longint          m;
    longint          xs;
    longint          ys;
    c1  = (v - gv) * 256;
    c2  = (gu - u) * 256;
    c3  = u * gv - v * gu;
    csq = c1 * c1 + c2 * c2 + c3 * c3;
    x   = 65536 + u * gu + v * gv;
    y   = longint'(int_sqrt(csq));
    z   = 0;
    // obtuse pair: turn by a right angle first
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd90 << 16;
    end
    m = (x > y) ? x : y;
    if (m == 0) return 0;
    while (m < (64'sd1 << 32)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < 22; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ROT_ANGLE[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ROT_ANGLE[i];
      end
    end
    if (z < 0) return 0;
    z = (z + 128) >>> 8;
    return (z > 46080) ? 46080 : z;
  endfunction

  function automatic longint unsigned sat_inc(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    return (b > lim - a) ? lim : a + b;
  endfunction

  // update the statistics for one pixel and queue its expected result
  task automatic account_pixel(ofea_pkg::ofea_in_t p);
    longint unsigned     ae;
    longint unsigned     ee;
    ofea_pkg::ofea_out_t r;
    ae = 0;
    ee = 0;
    if (p.clear_stats) begin
      pixel_cnt = 0;
      ang_sum   = 0;
      dist_sum  = 0;
      for (int k = 0; k < 3; k++) begin
        ang_over[k]  = 0;
        dist_over[k] = 0;
      end
    end
    if (p.pixel_valid) begin
      ae        = angle_error(p.flow_u, p.flow_v, p.truth_u, p.truth_v);
      ee        = dist_error(p.flow_u, p.flow_v, p.truth_u, p.truth_v);
      pixel_cnt = sat_inc(pixel_cnt, 1, ofea_pkg::CNT_MAX);
      ang_sum   = sat_inc(ang_sum, ae, ofea_pkg::AS_MAX);
      dist_sum  = sat_inc(dist_sum, ee, ofea_pkg::ES_MAX);
      for (int k = 0; k < 3; k++) begin
        if (ae >= ang_thr[k]) ang_over[k] = sat_inc(ang_over[k], 1, ofea_pkg::CNT_MAX);
        if (ee >= dist_thr[k]) dist_over[k] = sat_inc(dist_over[k], 1, ofea_pkg::CNT_MAX);
      end
    end
    r.angular_error      = 16'(ae);
    r.endpoint_error     = 17'(ee);
    r.valid_pixels       = 32'(pixel_cnt);
    r.angular_error_sum  = 48'(ang_sum);
    r.endpoint_error_sum = 50'(dist_sum);
    r.angular_over_0     = 32'(ang_over[0]);
    r.angular_over_1     = 32'(ang_over[1]);
    r.angular_over_2     = 32'(ang_over[2]);
    r.endpoint_over_0    = 32'(dist_over[0]);
    r.endpoint_over_1    = 32'(dist_over[1]);
    r.endpoint_over_2    = 32'(dist_over[2]);
    pending_results = {pending_results, r};
  endtask

  // send one pixel request; called and returning at a falling edge
  task automatic send_pixel(ofea_pkg::ofea_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= p;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    account_pixel(p);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [15:0] u, logic [15:0] v, logic [15:0] gu, logic [15:0] gv,
                             logic valid, logic clr);
    ofea_pkg::ofea_in_t p;
    p.flow_u      = u;
    p.flow_v      = v;
    p.truth_u     = gu;
    p.truth_v     = gv;
    p.pixel_valid = valid;
    p.clear_stats = clr;
    send_pixel(p);
  endtask

  // stop sending and wait until every expected result has been popped
  task automatic drain;
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one register write; only while idle
  task automatic write_reg(logic [7:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx <= ofea_pkg::CFG_AE_THR_2) ang_thr[idx] = data[15:0];
    else if (idx <= ofea_pkg::CFG_EE_THR_2) dist_thr[idx - ofea_pkg::CFG_EE_THR_0] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_thresholds(logic [16:0] a0, logic [16:0] a1, logic [16:0] a2,
                                logic [16:0] e0, logic [16:0] e1, logic [16:0] e2);
    drain();
    write_reg(ofea_pkg::CFG_AE_THR_0, a0);
    write_reg(ofea_pkg::CFG_AE_THR_1, a1);
    write_reg(ofea_pkg::CFG_AE_THR_2, a2);
    write_reg(ofea_pkg::CFG_EE_THR_0, e0);
    write_reg(ofea_pkg::CFG_EE_THR_1, e1);
    write_reg(ofea_pkg::CFG_EE_THR_2, e2);
  endtask

  // random pixel: mostly realistic flows, some full range and masked ones
  function automatic ofea_pkg::ofea_in_t random_pixel;
    ofea_pkg::ofea_in_t p;
    int                 sel;
    sel = $urandom_range(99);
    p.flow_u      = 16'($urandom);
    p.flow_v      = 16'($urandom);
    p.truth_u     = 16'($urandom);
    p.truth_v     = 16'($urandom);
    p.pixel_valid = (sel < 90);
    p.clear_stats = ($urandom_range(39) == 0);
    if (sel < 55) begin
      p.flow_u  = 16'($signed($urandom_range(4095)) - 2048);
      p.flow_v  = 16'($signed($urandom_range(4095)) - 2048);
      p.truth_u = 16'(p.flow_u + $signed($urandom_range(511)) - 256);
      p.truth_v = 16'(p.flow_v + $signed($urandom_range(511)) - 256);
    end else if (sel < 65) begin
      p.truth_u = -p.flow_u;
      p.truth_v = -p.flow_v;
    end
    return p;
  endfunction

  // extremes, masking, clearing and the obtuse case
  task automatic test_directed;
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h0100, 16'h0000, 16'h0000, 16'h0100, 1'b1, 1'b0);
    send_fields(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_fields(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_fields(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_fields(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
    send_fields(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 1'b1, 1'b0);
    send_fields(16'h0400, 16'h0300, 16'hFC00, 16'hFD00, 1'b1, 1'b0);
    send_fields(16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
    send_fields(16'h0200, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_fields(16'h0010, 16'hFFF0, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h0300, 16'h0100, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_fields(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'hFF00, 16'h0080, 16'h0100, 16'hFF80, 1'b1, 1'b0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pixel(random_pixel());
  endtask

  // threshold settings at the extremes, plus ignored indexes and masked data
  task automatic test_config_extremes;
    set_thresholds(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    test_random(20);
    set_thresholds(17'd46080, 17'h1FFFF, 17'h1B400, 17'd92682, 17'h1FFFF, 17'd0);
    write_reg(CFG_SPARE_LOW, 17'h00001);
    write_reg(CFG_SPARE_HIGH, 17'h00002);
    send_fields(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0);
    send_fields(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0);
    test_random(20);
  endtask

  // random thresholds then a phase of random pixels under given idling
  task automatic test_phase(int idle_pct, int stall_pct);
    set_thresholds(17'($urandom_range(46080)), 17'($urandom_range(2560)),
                   17'($urandom_range(12800)), 17'($urandom_range(1024)),
                   17'($urandom_range(8192)), 17'($urandom_range(92682)));
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    test_random(RANDOM_PIXELS);
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    ofea_pkg::ofea_out_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
      end else begin
        e = pending_results.pop_front();
        check_field("angular_error", e.angular_error, out_item_o.angular_error);
        check_field("endpoint_error", e.endpoint_error, out_item_o.endpoint_error);
        check_field("valid_pixels", e.valid_pixels, out_item_o.valid_pixels);
        check_field("angular_error_sum", e.angular_error_sum, out_item_o.angular_error_sum);
        check_field("endpoint_error_sum", e.endpoint_error_sum, out_item_o.endpoint_error_sum);
        check_field("angular_over_0", e.angular_over_0, out_item_o.angular_over_0);
        check_field("angular_over_1", e.angular_over_1, out_item_o.angular_over_1);
        check_field("angular_over_2", e.angular_over_2, out_item_o.angular_over_2);
        check_field("endpoint_over_0", e.endpoint_over_0, out_item_o.endpoint_over_0);
        check_field("endpoint_over_1", e.endpoint_over_1, out_item_o.endpoint_over_1);
        check_field("endpoint_over_2", e.endpoint_over_2, out_item_o.endpoint_over_2);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_item_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    ang_thr       = '{ofea_pkg::AE_THR_RST0, ofea_pkg::AE_THR_RST1, ofea_pkg::AE_THR_RST2};
    dist_thr      = '{ofea_pkg::EE_THR_RST0, ofea_pkg::EE_THR_RST1, ofea_pkg::EE_THR_RST2};
    pixel_cnt     = 0;
    ang_sum       = 0;
    dist_sum      = 0;
    ang_over      = '{0, 0, 0};
    dist_over     = '{0, 0, 0};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_extremes();
    test_phase(0, 0);
    test_phase(53, 0);
    test_phase(0, 53);
    test_phase(24, 24);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
